// File: rtl/core/tbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and constants of the translated block cache
// Transaction payloads, operation and status codes, and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tbc_pkg;

	// Operation codes carried in the func field.
	localparam logic [2:0] FUNC_LOOKUP = 3'd0;
	localparam logic [2:0] FUNC_INSERT = 3'd1;
	localparam logic [2:0] FUNC_FLUSH  = 3'd2;
	localparam logic [2:0] FUNC_INVAL  = 3'd3;
	localparam logic [2:0] FUNC_EMIT   = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MISS      = 2'd1;
	localparam logic [1:0] ST_POOL_FULL = 2'd2;
	localparam logic [1:0] ST_BAD_COUNT = 2'd3;

	// Multiplicative hash constant and the shift that picks the bucket bits.
	localparam logic [31:0] HASH_MUL   = 32'd2654435761;
	localparam int          HASH_SHIFT = 16;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] guest_addr;
		logic [25:0] host_offset;
		logic [31:0] range_end;
		logic [10:0] word_count;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [25:0] found_offset;
		logic        flushed;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       ld_hash;
		logic       head_rd_bkt;
		logic       cur_from_head;
		logic       cur_from_next;
		logic       prev_to_nil;
		logic       prev_to_cur;
		logic       ins_commit;
		logic       unlink_push;
		logic       clr_step;
		logic       bkt_clear;
		logic       bkt_inc;
		logic       pool_reset;
		logic       emit_commit;
		logic       set_flushed;
		logic       res_init;
		logic       res_st_ld;
		logic [1:0] res_st;
		logic       res_hit;
		logic       ld_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] func;
		logic       hit;
		logic       in_range;
		logic       range_empty;
		logic       cur_nil;
		logic       bkt_last;
		logic       pool_full;
		logic       cnt_bad;
		logic       overflow;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/translated_block_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// translated_block_cache: hashed code cache with a bump allocator
// Maps guest addresses to code-region offsets through chained hash buckets
// and hands out aligned space in the code region.
// ----------------------------------------------------------------------------
// One transaction is worked at a time, and every transaction returns exactly
// one result. A lookup walks its chain one entry at a time: each step reads
// the entry memories once and compares the key in the next cycle. Flush
// sweeps the bucket heads one per cycle, and an emit that wraps the region
// includes that sweep. Invalidate walks every bucket unless its range is
// empty. After reset, the block clears the bucket heads before it takes its
// first transaction. BUCKETS and ALIGN_BYTES must be powers of two; the block
// itself does not check this.
module translated_block_cache import tbc_pkg::*; #(
	parameter int BUCKETS         = 1024,
	parameter int ENTRIES         = 1024,
	parameter int REGION_BYTES    = 67108864,
	parameter int MAX_BLOCK_BYTES = 4096,
	parameter int ALIGN_BYTES     = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	cmd_t cmd;
	sts_t sts;

	tbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tbc_dp #(
		.BUCKETS         (BUCKETS),
		.ENTRIES         (ENTRIES),
		.REGION_BYTES    (REGION_BYTES),
		.MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
		.ALIGN_BYTES     (ALIGN_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_valid && in_ready),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// File: rtl/core/tbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_ctrl: operation sequencer of the translated block cache
// Steps each operation through hashing, chain walks, bucket sweeps and the
// allocation, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tbc_ctrl import tbc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [3:0] S_RST   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_HEAD  = 4'd3;
	localparam logic [3:0] S_HDAT  = 4'd4;
	localparam logic [3:0] S_WRD   = 4'd5;
	localparam logic [3:0] S_WCHK  = 4'd6;
	localparam logic [3:0] S_CLR   = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;
	localparam logic [3:0] S_IHEAD = 4'd9;
	localparam logic [3:0] S_IHDAT = 4'd10;
	localparam logic [3:0] S_IRD   = 4'd11;
	localparam logic [3:0] S_ICHK  = 4'd12;
	localparam logic [3:0] S_FIN   = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_RST: begin
				cmd.clr_step = 1'b1;
				if (sts.bkt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.res_init  = 1'b1;
					cmd.bkt_clear = 1'b1;
					state_d       = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.func)
					FUNC_LOOKUP, FUNC_INSERT: begin
						cmd.ld_hash = 1'b1;
						state_d     = S_HEAD;
					end
					FUNC_FLUSH: state_d = S_CLR;
					FUNC_INVAL: state_d = sts.range_empty ? S_FIN : S_IHEAD;
					FUNC_EMIT: begin
						if (sts.cnt_bad) begin
							cmd.res_st_ld = 1'b1;
							cmd.res_st    = ST_BAD_COUNT;
							state_d       = S_FIN;
						end else if (sts.overflow) begin
							cmd.set_flushed = 1'b1;
							state_d         = S_CLR;
						end else begin
							state_d = S_EMIT;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_HEAD: state_d = S_HDAT;
			S_HDAT: begin
				if (sts.func == FUNC_LOOKUP) begin
					cmd.cur_from_head = 1'b1;
					state_d           = S_WRD;
				end else if (sts.pool_full) begin
					cmd.res_st_ld = 1'b1;
					cmd.res_st    = ST_POOL_FULL;
					state_d       = S_FIN;
				end else begin
					cmd.ins_commit = 1'b1;
					state_d        = S_FIN;
				end
			end
			S_WRD: begin
				if (sts.cur_nil) begin
					cmd.res_st_ld = 1'b1;
					cmd.res_st    = ST_MISS;
					state_d       = S_FIN;
				end else begin
					state_d = S_WCHK;
				end
			end
			S_WCHK: begin
				if (sts.hit) begin
					cmd.res_hit = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.cur_from_next = 1'b1;
					state_d           = S_WRD;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.bkt_last) begin
					cmd.pool_reset = 1'b1;
					state_d        = (sts.func == FUNC_EMIT) ? S_EMIT : S_FIN;
				end
			end
			S_EMIT: begin
				cmd.emit_commit = 1'b1;
				state_d         = S_FIN;
			end
			S_IHEAD: begin
				cmd.head_rd_bkt = 1'b1;
				state_d         = S_IHDAT;
			end
			S_IHDAT: begin
				cmd.cur_from_head = 1'b1;
				cmd.prev_to_nil   = 1'b1;
				state_d           = S_IRD;
			end
			S_IRD: begin
				if (!sts.cur_nil) begin
					state_d = S_ICHK;
				end else if (sts.bkt_last) begin
					state_d = S_FIN;
				end else begin
					cmd.bkt_inc = 1'b1;
					state_d     = S_IHEAD;
				end
			end
			S_ICHK: begin
				if (sts.in_range) begin
					cmd.unlink_push = 1'b1;
				end else begin
					cmd.prev_to_cur = 1'b1;
				end
				cmd.cur_from_next = 1'b1;
				state_d           = S_IRD;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/tbc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_dp: datapath of the translated block cache
// Holds the bucket heads, the entry pool, the free stack, the bump offset,
// the hash unit and the output register.
// ----------------------------------------------------------------------------
module tbc_dp import tbc_pkg::*; #(
	parameter int BUCKETS         = 1024,
	parameter int ENTRIES         = 1024,
	parameter int REGION_BYTES    = 67108864,
	parameter int MAX_BLOCK_BYTES = 4096,
	parameter int ALIGN_BYTES     = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_accept,
	input  wire in_t  in_data,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] NIL      = IW'(ENTRIES);
	localparam logic [27:0]   ALIGN_M1 = 28'(ALIGN_BYTES - 1);

	// Storage.
	logic [IW-1:0] head_mem [BUCKETS];
	logic [31:0]   key_mem  [ENTRIES];
	logic [25:0]   val_mem  [ENTRIES];
	logic [IW-1:0] next_mem [ENTRIES];
	logic [EW-1:0] stk_mem  [ENTRIES];

	logic [IW-1:0] head_rdata;
	logic [31:0]   key_rdata;
	logic [25:0]   val_rdata;
	logic [IW-1:0] next_rdata;
	logic [EW-1:0] stk_rdata;

	in_t           req_q;
	logic [BW-1:0] hash_q;
	logic [BW-1:0] bkt_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] prev_q;
	logic [IW-1:0] fsp_q;
	logic [IW-1:0] fresh_q;
	logic [26:0]   bump_q;
	out_t          res_q;
	out_t          out_q;
	logic          out_valid_q;

	logic [31:0]   prod;
	logic [12:0]   size;
	logic [27:0]   bump_sum;
	logic [27:0]   bump_align;
	logic [EW-1:0] e_alloc;
	logic [BW-1:0] head_raddr;
	logic          head_we;
	logic [BW-1:0] head_waddr;
	logic [IW-1:0] head_wdata;
	logic          next_we;
	logic [EW-1:0] next_waddr;
	logic [IW-1:0] next_wdata;

	// Hash, sizes and the entry that an insert would take.
	assign prod       = req_q.guest_addr * HASH_MUL;
	assign size       = {req_q.word_count, 2'b00};
	assign bump_sum   = {1'b0, bump_q} + 28'(size);
	assign bump_align = (bump_sum + ALIGN_M1) & ~ALIGN_M1;
	assign e_alloc    = (fsp_q != '0) ? stk_rdata : fresh_q[EW-1:0];

	// Status toward the controller.
	always_comb begin
		sts.func        = req_q.func;
		sts.hit         = (key_rdata == req_q.guest_addr);
		sts.in_range    = (key_rdata >= req_q.guest_addr) && (key_rdata < req_q.range_end);
		sts.range_empty = (req_q.guest_addr >= req_q.range_end);
		sts.cur_nil     = (cur_q == NIL);
		sts.bkt_last    = (bkt_q == BW'(BUCKETS - 1));
		sts.pool_full   = (fsp_q == '0) && (fresh_q == NIL);
		sts.cnt_bad     = (req_q.word_count == '0) || (32'(size) > 32'(MAX_BLOCK_BYTES));
		sts.overflow    = (bump_sum > 28'(REGION_BYTES));
		sts.out_free    = !out_valid_q || out_ready;
	end

	// Write port selection for the heads and the next links.
	always_comb begin
		head_raddr = cmd.head_rd_bkt ? bkt_q : hash_q;
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = NIL;
		next_we    = 1'b0;
		next_waddr = e_alloc;
		next_wdata = head_rdata;
		if (cmd.clr_step) begin
			head_we = 1'b1;
		end else if (cmd.ins_commit) begin
			head_we    = 1'b1;
			head_waddr = hash_q;
			head_wdata = IW'(e_alloc);
			next_we    = 1'b1;
		end else if (cmd.unlink_push) begin
			if (prev_q == NIL) begin
				head_we    = 1'b1;
				head_wdata = next_rdata;
			end else begin
				next_we    = 1'b1;
				next_waddr = prev_q[EW-1:0];
				next_wdata = next_rdata;
			end
		end
	end

	// Memories with registered reads.
	always_ff @(posedge clk) begin
		head_rdata <= head_mem[head_raddr];
		key_rdata  <= key_mem[cur_q[EW-1:0]];
		val_rdata  <= val_mem[cur_q[EW-1:0]];
		next_rdata <= next_mem[cur_q[EW-1:0]];
		stk_rdata  <= stk_mem[EW'(fsp_q - 1'b1)];
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		if (cmd.ins_commit) begin
			key_mem[e_alloc] <= req_q.guest_addr;
			val_mem[e_alloc] <= req_q.host_offset;
		end
		if (cmd.unlink_push) begin
			stk_mem[fsp_q[EW-1:0]] <= cur_q[EW-1:0];
		end
	end

	// Request, hash and chain walk registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q <= in_data;
		end
		if (cmd.ld_hash) begin
			hash_q <= prod[HASH_SHIFT +: BW];
		end
		if (cmd.cur_from_head) begin
			cur_q <= head_rdata;
		end else if (cmd.cur_from_next) begin
			cur_q <= next_rdata;
		end
		if (cmd.prev_to_nil) begin
			prev_q <= NIL;
		end else if (cmd.prev_to_cur) begin
			prev_q <= cur_q;
		end
	end

	// Result being built for the current transaction.
	always_ff @(posedge clk) begin
		if (cmd.res_init) begin
			res_q <= '0;
		end else begin
			if (cmd.res_st_ld) begin
				res_q.status <= cmd.res_st;
			end
			if (cmd.res_hit) begin
				res_q.found_offset <= val_rdata;
			end
			if (cmd.emit_commit) begin
				res_q.found_offset <= bump_q[25:0];
			end
			if (cmd.set_flushed) begin
				res_q.flushed <= 1'b1;
			end
		end
	end

	// Sweep counter, pool pointers and bump offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_q   <= '0;
			fsp_q   <= '0;
			fresh_q <= '0;
			bump_q  <= '0;
		end else begin
			if (cmd.bkt_clear) begin
				bkt_q <= '0;
			end else if (cmd.clr_step || cmd.bkt_inc) begin
				bkt_q <= bkt_q + 1'b1;
			end
			if (cmd.pool_reset) begin
				fsp_q   <= '0;
				fresh_q <= '0;
				bump_q  <= '0;
			end else begin
				if (cmd.ins_commit) begin
					if (fsp_q != '0) begin
						fsp_q <= fsp_q - 1'b1;
					end else begin
						fresh_q <= fresh_q + 1'b1;
					end
				end
				if (cmd.unlink_push) begin
					fsp_q <= fsp_q + 1'b1;
				end
				if (cmd.emit_commit) begin
					bump_q <= bump_align[26:0];
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the translated block cache
// Drives lookup, insert, flush, invalidate, emit and unknown-code transactions with random
// idling on both channels, predicts every result with a behavioral copy of
// the cache and bump allocator, and checks each result against it in order.
// ----------------------------------------------------------------------------
module tb_top;
	import tbc_pkg::*;

	localparam int BUCKETS      = 1024;
	localparam int ENTRIES      = 1024;
	localparam int REGION_BYTES = 67108864;
	localparam int MAX_BYTES    = 4096;
	localparam int ALIGN        = 16;
	localparam int NIL          = ENTRIES;
	localparam longint LIMIT    = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int errors = 0;
	longint cycles = 0;
	bit quiet = 0;
	int n_sent = 0, n_flushes = 0, n_wraps = 0, n_full = 0, n_hits = 0;

	translated_block_cache dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mismatch reporting: one line per mismatch, for the first 30 mismatches.
	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 30) $display("MISMATCH at cycle %0d: %s", cycles, what);
	endtask

	// Cache predictor and the queue of pending results.
	class cache_scoreboard;
		int head[BUCKETS];
		logic [31:0] key[ENTRIES];
		logic [25:0] val[ENTRIES];
		int nxt[ENTRIES];
		bit free_map[ENTRIES];
		longint bump;
		out_t pending[$];

		function new();
			flush_all();
		endfunction

		function int bucket_of(logic [31:0] a);
			logic [31:0] p;
			p = a * HASH_MUL;
			return int'((p >> HASH_SHIFT) & 32'(BUCKETS - 1));
		endfunction

		function void flush_all();
			foreach (head[i]) head[i] = NIL;
			foreach (free_map[i]) free_map[i] = 1'b1;
			bump = 0;
		endfunction

		// Works out the result of one accepted transaction.
		function void note_input(in_t t);
			out_t r;
			int e, b, prev, nx;
			longint sz;
			r = '0;
			case (t.func)
				FUNC_LOOKUP: begin
					r.status = ST_MISS;
					e = head[bucket_of(t.guest_addr)];
					while (e != NIL) begin
						if (key[e] == t.guest_addr) begin
							r.status = ST_OK;
							r.found_offset = val[e];
							break;
						end
						e = nxt[e];
					end
				end
				FUNC_INSERT: begin
					for (e = 0; e < NIL; e++) if (free_map[e]) break;
					if (e >= NIL) r.status = ST_POOL_FULL;
					else begin
						b = bucket_of(t.guest_addr);
						free_map[e] = 1'b0;
						key[e] = t.guest_addr;
						val[e] = t.host_offset;
						nxt[e] = head[b];
						head[b] = e;
					end
				end
				FUNC_FLUSH: flush_all();
				FUNC_INVAL: begin
					for (b = 0; b < BUCKETS; b++) begin
						prev = NIL;
						e = head[b];
						while (e != NIL) begin
							nx = nxt[e];
							if (key[e] >= t.guest_addr && key[e] < t.range_end) begin
								if (prev == NIL) head[b] = nx;
								else nxt[prev] = nx;
								free_map[e] = 1'b1;
							end else prev = e;
							e = nx;
						end
					end
				end
				FUNC_EMIT: begin
					sz = longint'(t.word_count) * 4;
					if (t.word_count == 0 || sz > MAX_BYTES) r.status = ST_BAD_COUNT;
					else begin
						if (bump + sz > REGION_BYTES) begin
							flush_all();
							r.flushed = 1'b1;
						end
						r.found_offset = bump[25:0];
						bump = ((bump + sz + ALIGN - 1) / ALIGN) * ALIGN;
						bump &= 64'h7FFFFFF;
					end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		// Compares one accepted result with the oldest expectation.
		task check_result(out_t got);
			out_t exp_r;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing expected");
				return;
			end
			exp_r = pending.pop_front();
			if (got.status != exp_r.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, exp_r.status));
			if (got.found_offset != exp_r.found_offset)
				report_mismatch($sformatf("found_offset %h, expected %h",
					got.found_offset, exp_r.found_offset));
			if (got.flushed != exp_r.flushed)
				report_mismatch($sformatf("flushed %0d, expected %0d", got.flushed, exp_r.flushed));
		endtask
	endclass

	cache_scoreboard sb = new();

	// Cycle count and the run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stalls, checking on accepted results.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_result(out_data);
			if (out_data.status == ST_OK && out_data.flushed) n_wraps++;
		end
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
	end

	// Sends one transaction, with a random gap before it unless quiet is set.
	task automatic send_item(input in_t t);
		if (!quiet) begin
			while ($urandom_range(99) < 17) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_data <= t;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(t);
		n_sent++;
		if (t.func == FUNC_FLUSH) n_flushes++;
	endtask

	function automatic in_t make_item(logic [2:0] f, logic [31:0] a, logic [25:0] o,
			logic [31:0] e, logic [10:0] c);
		in_t t;
		t.func = f;
		t.guest_addr = a;
		t.host_offset = o;
		t.range_end = e;
		t.word_count = c;
		return t;
	endfunction

	// Waits until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// Random address drawn from a small pool so that lookups hit.
	function automatic logic [31:0] pick_addr(ref logic [31:0] pool[$]);
		if (pool.size() != 0 && $urandom_range(3) != 0)
			return pool[$urandom_range(pool.size() - 1)];
		return $urandom();
	endfunction

	initial begin
		logic [31:0] addrs[$];
		logic [31:0] a;
		int k, pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, shadowing, ranges, counts, unknown codes.
		send_item(make_item(FUNC_LOOKUP, 32'h0, 26'h0, 32'h0, 11'h0));
		send_item(make_item(FUNC_INSERT, 32'h0, 26'h3FFFFFF, 32'hFFFFFFFF, 11'h7FF));
		send_item(make_item(FUNC_INSERT, 32'hFFFFFFFF, 26'h1, 32'h0, 11'h0));
		send_item(make_item(FUNC_INSERT, 32'hFFFFFFFF, 26'h2AAAAAA, 32'h0, 11'h0));
		send_item(make_item(FUNC_LOOKUP, 32'hFFFFFFFF, 26'h0, 32'h0, 11'h0));
		send_item(make_item(FUNC_LOOKUP, 32'h0, 26'h0, 32'h0, 11'h0));
		send_item(make_item(FUNC_INVAL, 32'h10, 26'h0, 32'h10, 11'h0));
		send_item(make_item(FUNC_INVAL, 32'hFFFFFFFF, 26'h0, 32'h0, 11'h0));
		send_item(make_item(FUNC_LOOKUP, 32'h0, 26'h0, 32'h0, 11'h0));
		send_item(make_item(FUNC_INVAL, 32'h80000000, 26'h0, 32'hFFFFFFFF, 11'h0));
		send_item(make_item(FUNC_LOOKUP, 32'hFFFFFFFF, 26'h0, 32'h0, 11'h0));
		send_item(make_item(FUNC_EMIT, 32'h0, 26'h0, 32'h0, 11'd0));
		send_item(make_item(FUNC_EMIT, 32'h0, 26'h0, 32'h0, 11'd1025));
		send_item(make_item(FUNC_EMIT, 32'h0, 26'h0, 32'h0, 11'h7FF));
		send_item(make_item(FUNC_EMIT, 32'h0, 26'h0, 32'h0, 11'd1));
		send_item(make_item(FUNC_EMIT, 32'h0, 26'h0, 32'h0, 11'd1024));
		send_item(make_item(3'd5, 32'h1234, 26'h0, 32'h0, 11'h0));
		send_item(make_item(3'd6, 32'h0, 26'h0, 32'h0, 11'h0));
		send_item(make_item(3'd7, 32'hFFFFFFFF, 26'h3FFFFFF, 32'hFFFFFFFF, 11'h7FF));
		send_item(make_item(FUNC_FLUSH, 32'h0, 26'h0, 32'h0, 11'h0));
		send_item(make_item(FUNC_LOOKUP, 32'h0, 26'h0, 32'h0, 11'h0));

		// Fill the pool past its size to reach pool full, then invalidate part of it and check an insert and a lookup.
		quiet = 1;
		for (k = 0; k < ENTRIES + 3; k++)
			send_item(make_item(FUNC_INSERT, $urandom(), 26'($urandom()), $urandom(),
				11'($urandom())));
		n_full = 3;
		quiet = 0;
		send_item(make_item(FUNC_INVAL, 32'h0, 26'h0, 32'h40000000, 11'h0));
		send_item(make_item(FUNC_INSERT, 32'h5, 26'h77, 32'h0, 11'h0));
		send_item(make_item(FUNC_LOOKUP, 32'h5, 26'h0, 32'h0, 11'h0));
		drain();
		send_item(make_item(FUNC_LOOKUP, 32'h5, 26'h0, 32'h0, 11'h0));

		// Random part: mostly inserts and lookups on a reused address set.
		for (k = 0; k < 150; k++) begin
			pick = $urandom_range(99);
			a = pick_addr(addrs);
			if (pick < 35) begin
				if (addrs.size() < 64) addrs.push_back(a);
				send_item(make_item(FUNC_INSERT, a, 26'($urandom()), $urandom(),
					11'($urandom())));
			end else if (pick < 75)
				send_item(make_item(FUNC_LOOKUP, a, 26'($urandom()), $urandom(),
					11'($urandom())));
			else if (pick < 78)
				send_item(make_item(FUNC_INVAL, a, 26'($urandom()),
					a + $urandom_range(1 << 28), 11'($urandom())));
			else if (pick < 79)
				send_item(make_item(FUNC_INVAL, $urandom(), 26'($urandom()), $urandom(),
					11'($urandom())));
			else if (pick < 80)
				send_item(make_item(FUNC_FLUSH, $urandom(), 26'($urandom()), $urandom(),
					11'($urandom())));
			else if (pick < 95)
				send_item(make_item(FUNC_EMIT, a, 26'($urandom()), $urandom(),
					($urandom_range(9) == 0) ? 11'($urandom()) : 11'($urandom_range(1, 1024))));
			else
				send_item(make_item(3'($urandom_range(5, 7)), $urandom(), 26'($urandom()),
					$urandom(), 11'($urandom())));
			// One pause that lets every pending result return.
			if (k == 75) drain();
		end

		drain();
		repeat (4 * BUCKETS + 2 * ENTRIES + 50) @(posedge clk);
		if (sb.pending.size() != 0) report_mismatch("results still expected at the end");
		$display("Covered %0d transactions: lookups with %0d pool-full inserts, %0d flushes,",
			n_sent, n_full, n_flushes);
		$display("invalidate ranges, emits with %0d region wraps, unknown codes.", n_wraps);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
